### rtl/malu_pkg.sv
// ============================================================================
// malu_pkg
// Shared types and constants of the 8051-style accumulator ALU.
// ============================================================================
`default_nettype none

package malu_pkg;

  // Operation codes; codes above OP_XCHD leave everything unchanged.
  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADDC = 5'd1,
    OP_SUBB = 5'd2,
    OP_INC  = 5'd3,
    OP_DEC  = 5'd4,
    OP_ANL  = 5'd5,
    OP_ORL  = 5'd6,
    OP_XRL  = 5'd7,
    OP_CPL  = 5'd8,
    OP_RR   = 5'd9,
    OP_RRC  = 5'd10,
    OP_RL   = 5'd11,
    OP_RLC  = 5'd12,
    OP_SWAP = 5'd13,
    OP_DA   = 5'd14,
    OP_MUL  = 5'd15,
    OP_DIV  = 5'd16,
    OP_CMP  = 5'd17,
    OP_XCHD = 5'd18
  } op_e;

  // Pipeline depth and divider bits resolved in each stage after the first.
  localparam int unsigned NumStages = 4;
  localparam logic [1:0] DivSteps [NumStages-1] = '{2'd3, 2'd3, 2'd2};

  // Contents of one pipeline stage. For a divide, acc holds the
  // dividend/quotient shift word and sec the partial remainder.
  typedef struct packed {
    logic       is_div;
    logic [7:0] acc;
    logic [7:0] sec;
    logic [7:0] dvs;
    logic       carry;
    logic       aux_carry;
    logic       overflow;
    logic       not_equal;
  } stage_t;

endpackage

`default_nettype wire

### rtl/malu_req_if.sv
// ============================================================================
// malu_req_if
// Request channel: one ALU operation with its operands and flags.
// ============================================================================
`default_nettype none

interface malu_req_if;
  logic       valid;
  logic       ready;
  logic [4:0] req_type;
  logic [7:0] acc_in;
  logic [7:0] operand_in;
  logic       carry_in;
  logic       aux_carry_in;
  logic       overflow_in;

  modport source (
    output valid, req_type, acc_in, operand_in, carry_in, aux_carry_in, overflow_in,
    input  ready
  );

  modport sink (
    input  valid, req_type, acc_in, operand_in, carry_in, aux_carry_in, overflow_in,
    output ready
  );
endinterface

`default_nettype wire

### rtl/malu_rsp_if.sv
// ============================================================================
// malu_rsp_if
// Response channel: new accumulator, second byte, flags and inequality mark.
// ============================================================================
`default_nettype none

interface malu_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] acc_out;
  logic [7:0] second_out;
  logic       carry_out;
  logic       aux_carry_out;
  logic       overflow_out;
  logic       not_equal;

  modport source (
    output valid, acc_out, second_out, carry_out, aux_carry_out, overflow_out,
           not_equal,
    input  ready
  );

  modport sink (
    input  valid, acc_out, second_out, carry_out, aux_carry_out, overflow_out,
           not_equal,
    output ready
  );
endinterface

`default_nettype wire

### rtl/mcs51_alu_flags.sv
// ============================================================================
// mcs51_alu_flags
// 8051-style accumulator ALU with flag update, four register stages deep.
// ============================================================================
//
//   channel | dir | handshake     | content
//   --------+-----+---------------+-------------------------------------------
//   req_i   | in  | valid / ready | operation, A, operand, C, AC, OV
//   rsp_o   | out | valid / ready | new A, second byte, C, AC, OV, not_equal
//
// One item per cycle is accepted while req_i.ready is high. Each result is
// presented from the last of stages 0 to 3, once per item, in order.
// Stage 0 evaluates all operations but the divide, the multiply among them,
// and a divide by zero; stages 1 to 3 resolve three, three and two quotient
// bits of the restoring division. Reset clears the stage valid bits only. A
// stalled stage holds its item while earlier empty stages keep filling, so a
// stall loses nothing.
//
`default_nettype none

module mcs51_alu_flags
  import malu_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  malu_req_if.sink   req_i,
  malu_rsp_if.source rsp_o
);

  // --------------------------------------------------------------------------
  // Pipeline registers
  // --------------------------------------------------------------------------
  logic   [NumStages-1:0] vld_q;
  logic   [NumStages-1:0] rdy;
  stage_t                 st_q [NumStages];
  stage_t                 st_d [NumStages];

  // A stage takes a new item when it is empty or its item moves on.
  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || rsp_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign req_i.ready = rdy[0];

  // --------------------------------------------------------------------------
  // Divider: up to three restoring steps, shifting the quotient into the
  // dividend word while the remainder grows.
  // --------------------------------------------------------------------------
  function automatic stage_t div_run(stage_t s, logic [1:0] n);
    stage_t     r;
    logic [8:0] t;
    r = s;
    for (int i = 0; i < 3; i++) begin
      if (r.is_div && (i < int'(n))) begin
        t     = {r.sec, r.acc[7]};
        r.acc = {r.acc[6:0], 1'b0};
        if (t >= {1'b0, r.dvs}) begin
          r.sec    = 8'(t - {1'b0, r.dvs});
          r.acc[0] = 1'b1;
        end else begin
          r.sec = t[7:0];
        end
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stage 0: every operation but a nonzero divide finishes here.
  // --------------------------------------------------------------------------
  logic [7:0]  a;
  logic [7:0]  v;
  logic        cin;
  logic [8:0]  sum9;
  logic [4:0]  low5;
  logic [8:0]  da_lo;
  logic [7:0]  da_t;
  logic        da_c;
  logic [15:0] prod;

  assign a = req_i.acc_in;
  assign v = req_i.operand_in;

  always_comb begin
    st_d[0]           = '0;
    st_d[0].acc       = a;
    st_d[0].sec       = v;
    st_d[0].dvs       = v;
    st_d[0].carry     = req_i.carry_in;
    st_d[0].aux_carry = req_i.aux_carry_in;
    st_d[0].overflow  = req_i.overflow_in;
    st_d[0].not_equal = (a != v);
    cin   = 1'b0;
    sum9  = '0;
    low5  = '0;
    da_lo = {1'b0, a};
    da_t  = a;
    da_c  = req_i.carry_in;
    prod  = {8'd0, a} * {8'd0, v};

    case (op_e'(req_i.req_type))
      OP_ADD, OP_ADDC: begin
        cin = (op_e'(req_i.req_type) == OP_ADDC) ? req_i.carry_in : 1'b0;
        sum9 = {1'b0, a} + {1'b0, v} + {8'd0, cin};
        low5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
        st_d[0].acc       = sum9[7:0];
        st_d[0].carry     = sum9[8];
        st_d[0].aux_carry = low5[4];
        st_d[0].overflow  = ~(a[7] ^ v[7]) & (a[7] ^ sum9[7]);
      end
      OP_SUBB: begin
        cin  = req_i.carry_in;
        sum9 = {1'b0, a} - {1'b0, v} - {8'd0, cin};
        low5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};
        st_d[0].acc       = sum9[7:0];
        st_d[0].carry     = sum9[8];
        st_d[0].aux_carry = low5[4];
        st_d[0].overflow  = (a[7] ^ v[7]) & (a[7] ^ sum9[7]);
      end
      OP_INC:  st_d[0].acc = a + 8'd1;
      OP_DEC:  st_d[0].acc = a - 8'd1;
      OP_ANL:  st_d[0].acc = a & v;
      OP_ORL:  st_d[0].acc = a | v;
      OP_XRL:  st_d[0].acc = a ^ v;
      OP_CPL:  st_d[0].acc = ~a;
      OP_RR:   st_d[0].acc = {a[0], a[7:1]};
      OP_RRC: begin
        st_d[0].acc   = {req_i.carry_in, a[7:1]};
        st_d[0].carry = a[0];
      end
      OP_RL:   st_d[0].acc = {a[6:0], a[7]};
      OP_RLC: begin
        st_d[0].acc   = {a[6:0], req_i.carry_in};
        st_d[0].carry = a[7];
      end
      OP_SWAP: st_d[0].acc = {a[3:0], a[7:4]};
      OP_DA: begin
        // Low adjust may carry out of bit 7; C is only ever set here.
        if ((a[3:0] > 4'd9) || req_i.aux_carry_in) begin
          da_lo = {1'b0, a} + 9'h006;
          da_c  = da_c | da_lo[8];
        end
        da_t = da_lo[7:0];
        if ((da_t[7:4] > 4'd9) || da_c) begin
          da_t = da_t + 8'h60;
          da_c = 1'b1;
        end
        st_d[0].acc   = da_t;
        st_d[0].carry = da_c;
      end
      OP_MUL: begin
        st_d[0].acc      = prod[7:0];
        st_d[0].sec      = prod[15:8];
        st_d[0].carry    = 1'b0;
        st_d[0].overflow = |prod[15:8];
      end
      OP_DIV: begin
        st_d[0].carry = 1'b0;
        if (v == 8'd0) begin
          // Divide by zero finishes here with zero quotient and remainder.
          st_d[0].acc      = '0;
          st_d[0].sec      = '0;
          st_d[0].overflow = 1'b1;
        end else begin
          // Start the restoring divide with an empty remainder.
          st_d[0].is_div   = 1'b1;
          st_d[0].sec      = '0;
          st_d[0].overflow = 1'b0;
        end
      end
      OP_CMP:  st_d[0].carry = (a < v);
      OP_XCHD: begin
        st_d[0].acc = {a[7:4], v[3:0]};
        st_d[0].sec = {v[7:4], a[3:0]};
      end
      default: ;
    endcase

    // Stages 1 to 3: advance the divide; other items pass unchanged.
    for (int k = 1; k < NumStages; k++) begin
      st_d[k] = div_run(st_q[k-1], DivSteps[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= req_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (rdy[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Outputs straight from the last stage
  // --------------------------------------------------------------------------
  assign rsp_o.valid         = vld_q[NumStages-1];
  assign rsp_o.acc_out       = st_q[NumStages-1].acc;
  assign rsp_o.second_out    = st_q[NumStages-1].sec;
  assign rsp_o.carry_out     = st_q[NumStages-1].carry;
  assign rsp_o.aux_carry_out = st_q[NumStages-1].aux_carry;
  assign rsp_o.overflow_out  = st_q[NumStages-1].overflow;
  assign rsp_o.not_equal     = st_q[NumStages-1].not_equal;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Back-pressure reaches the input only when every stage is full and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> ((&vld_q) && !rsp_o.ready))
    else $error("input stalled with room in the pipeline");

  // An item leaving the third stage lands in the output stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NumStages-2] && rdy[NumStages-1]) |=> vld_q[NumStages-1])
    else $error("item dropped between the last two stages");

  // A finished divide by a nonzero divisor leaves a remainder below it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && st_q[NumStages-1].is_div && (st_q[NumStages-1].dvs != 8'd0))
      |-> (rsp_o.second_out < st_q[NumStages-1].dvs))
    else $error("divide remainder not below divisor");

endmodule

`default_nettype wire
